// ===== src/sptk_pkg.sv =====
// Shared types, constants and codes of the shared page key table.
package sptk_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int PAGE_BYTES_DEF    = 4096;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [31:0] TOP_ADDRESS_RESET = 32'h000A_0000;
    localparam logic [15:0] USERS_MAX         = 16'hFFFF;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISS     = 2'd1;
    localparam logic [1:0] STATUS_NO_FRAME = 2'd2;
    localparam logic [1:0] STATUS_KEY_ZERO = 2'd3;

    localparam logic CMD_GET     = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        OP_GET,
        OP_RELEASE,
        OP_ZERO
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_UPDATE
    } back_state_t;

    typedef struct packed {
        logic               command;
        logic signed [31:0] key;
        logic               frame_ok;
        logic        [19:0] new_frame;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [31:0] mapped_address;
        logic [19:0] entry_frame;
        logic        frame_released;
        logic [15:0] users_now;
    } rsp_item_t;

    // A classified request as it waits between the front and the back.
    typedef struct packed {
        op_t         op;
        logic [31:0] key;
        logic        frame_ok;
        logic [19:0] new_frame;
    } work_item_t;

    typedef struct packed {
        logic [31:0] key;
        logic [19:0] frame;
        logic [15:0] users;
    } entry_t;

    // Handshake between a producer and the queue, or the queue and a consumer.
    typedef struct packed {
        logic not_full;
        logic not_empty;
    } queue_status_t;

endpackage

// ===== src/shared_page_key_table_unit.sv =====
// Top level of the shared page key table: configuration register, front, queue and back.
//
// Requests enter on req (req_valid, req_stall) and one result item per request
// leaves on rsp (rsp_valid, rsp_stall). An item moves at a clock edge where its
// valid is high and its stall is low.
// The front registers and classifies each request; a two-item queue separates
// it from the back, which scans the table one entry per cycle through the
// memory read port, then applies the request with at most one memory write.
// A request passes through the back in order: it is taken from the queue, the
// table is scanned (the compare trailing the read), then the update is applied.
// A key of zero skips the scan and goes straight to the update.
// The result waits in an output register while rsp_stall is high; the back
// then holds its finished request, the queue fills, and req_stall rises.
// Reset empties the front, queue and output and marks every table entry free;
// top_address_reg returns to 0xA0000. The user writes it through cfg_write_en
// and cfg_write_data, only while no request is in flight; not enforced by the block.
module shared_page_key_table_unit
#(
    parameter int TABLE_ENTRIES = sptk_pkg::TABLE_ENTRIES_DEF,
    parameter int PAGE_BYTES    = sptk_pkg::PAGE_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  sptk_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output sptk_pkg::rsp_item_t rsp,
    input  logic                cfg_write_en,
    input  logic [31:0]         cfg_write_data
);

    logic [31:0]             top_address_reg;
    logic [31:0]             top_address_next;
    sptk_pkg::queue_status_t q_status;
    logic                    push;
    logic                    pop;
    sptk_pkg::work_item_t    push_item;
    sptk_pkg::work_item_t    head_item;

    assign top_address_next = cfg_write_en ? cfg_write_data : top_address_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_address_reg <= sptk_pkg::TOP_ADDRESS_RESET;
        end
        else
        begin
            top_address_reg <= top_address_next;
        end
    end

    sptk_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    sptk_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    sptk_back
    #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PAGE_BYTES    (PAGE_BYTES)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .top_address (top_address_reg),
        .q_status    (q_status),
        .head_item   (head_item),
        .pop         (pop),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

endmodule

// ===== src/sptk_front.sv =====
// Front part: takes request items, classifies them and hands them to the queue.
module sptk_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  sptk_pkg::req_item_t    req,
    input  sptk_pkg::queue_status_t q_status,
    output logic                   push,
    output sptk_pkg::work_item_t   push_item
);

    logic                 hold_valid_reg;
    logic                 hold_valid_next;
    sptk_pkg::work_item_t hold_reg;
    sptk_pkg::work_item_t hold_next;
    logic                 accept;
    sptk_pkg::op_t        op_class;

    assign req_stall = hold_valid_reg && !q_status.not_full;
    assign accept    = req_valid && !req_stall;
    assign push      = hold_valid_reg && q_status.not_full;
    assign push_item = hold_reg;

    always_comb
    begin
        if (req.key == '0)
        begin
            op_class = sptk_pkg::OP_ZERO;
        end
        else if (req.command == sptk_pkg::CMD_RELEASE)
        begin
            op_class = sptk_pkg::OP_RELEASE;
        end
        else
        begin
            op_class = sptk_pkg::OP_GET;
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (accept)
        begin
            hold_valid_next     = 1'b1;
            hold_next.op        = op_class;
            hold_next.key       = $unsigned(req.key);
            hold_next.frame_ok  = req.frame_ok;
            hold_next.new_frame = req.new_frame;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ===== src/sptk_queue.sv =====
// Short queue of classified items between the front and the back.
module sptk_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sptk_pkg::work_item_t    push_item,
    input  logic                    pop,
    output sptk_pkg::work_item_t    head_item,
    output sptk_pkg::queue_status_t q_status
);

    localparam int PTR_W = (sptk_pkg::QUEUE_DEPTH > 1) ? $clog2(sptk_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(sptk_pkg::QUEUE_DEPTH + 1);

    sptk_pkg::work_item_t slots_reg [sptk_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] head_ptr_reg;
    logic [PTR_W-1:0] head_ptr_next;
    logic [PTR_W-1:0] tail_ptr_reg;
    logic [PTR_W-1:0] tail_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_status.not_full  = (count_reg != CNT_W'(sptk_pkg::QUEUE_DEPTH));
    assign q_status.not_empty = (count_reg != '0);
    assign do_push   = push && q_status.not_full;
    assign do_pop    = pop && q_status.not_empty;
    assign head_item = slots_reg[head_ptr_reg];

    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        count_next    = count_reg;
        if (do_push)
        begin
            tail_ptr_next = (tail_ptr_reg == PTR_W'(sptk_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : tail_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            head_ptr_next = (head_ptr_reg == PTR_W'(sptk_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : head_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[tail_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/sptk_back.sv =====
// Back part: scans the table, applies a request and registers its result item.
module sptk_back
#(
    parameter int TABLE_ENTRIES = sptk_pkg::TABLE_ENTRIES_DEF,
    parameter int PAGE_BYTES    = sptk_pkg::PAGE_BYTES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [31:0]             top_address,
    input  sptk_pkg::queue_status_t q_status,
    input  sptk_pkg::work_item_t    head_item,
    output logic                    pop,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output sptk_pkg::rsp_item_t     rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [31:0] PAGE_STEP = 32'(PAGE_BYTES);

    sptk_pkg::entry_t table_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [TABLE_ENTRIES-1:0] used_next;

    sptk_pkg::back_state_t state_reg;
    sptk_pkg::back_state_t state_next;
    sptk_pkg::work_item_t  cur_reg;
    sptk_pkg::work_item_t  cur_next;

    // Read side of the scan: issue pointer and the offset of the page it names.
    logic [CNT_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] rd_ptr_next;
    logic [31:0]      iss_off_reg;
    logic [31:0]      iss_off_next;
    logic             rd_en;

    // Compare side of the scan, working on the registered read data in the cycle after the read.
    sptk_pkg::entry_t rdata_reg;
    logic             rused_reg;
    logic             cmp_valid_reg;
    logic             cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [IDX_W-1:0] cmp_idx_next;
    logic [31:0]      cmp_off_reg;
    logic [31:0]      cmp_off_next;

    logic             hit_found_reg;
    logic             hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] hit_idx_next;
    logic [31:0]      hit_off_reg;
    logic [31:0]      hit_off_next;
    logic [19:0]      hit_frame_reg;
    logic [19:0]      hit_frame_next;
    logic [15:0]      hit_users_reg;
    logic [15:0]      hit_users_next;
    logic             free_found_reg;
    logic             free_found_next;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_idx_next;
    logic [31:0]      free_off_reg;
    logic [31:0]      free_off_next;

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    sptk_pkg::rsp_item_t rsp_reg;
    sptk_pkg::rsp_item_t rsp_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    sptk_pkg::entry_t wr_data;
    sptk_pkg::rsp_item_t result;
    logic             out_free;
    logic [15:0]      users_inc;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign users_inc = (hit_users_reg == sptk_pkg::USERS_MAX) ?
                       hit_users_reg : hit_users_reg + 16'd1;

    // Outcome of the request once the scan has finished, with its table write.
    always_comb
    begin
        result    = '0;
        wr_en     = 1'b0;
        wr_idx    = hit_idx_reg;
        wr_data   = '0;
        used_next = used_reg;
        case (cur_reg.op)
            sptk_pkg::OP_ZERO:
            begin
                result.status = sptk_pkg::STATUS_KEY_ZERO;
            end
            sptk_pkg::OP_GET:
            begin
                if (hit_found_reg)
                begin
                    wr_en                 = 1'b1;
                    wr_data.key           = cur_reg.key;
                    wr_data.frame         = hit_frame_reg;
                    wr_data.users         = users_inc;
                    result.status         = sptk_pkg::STATUS_OK;
                    result.slot           = 4'(hit_idx_reg);
                    result.mapped_address = top_address - hit_off_reg;
                    result.entry_frame    = hit_frame_reg;
                    result.users_now      = users_inc;
                end
                else if (!free_found_reg)
                begin
                    result.status = sptk_pkg::STATUS_MISS;
                end
                else if (!cur_reg.frame_ok)
                begin
                    result.status = sptk_pkg::STATUS_NO_FRAME;
                end
                else
                begin
                    wr_en                   = 1'b1;
                    wr_idx                  = free_idx_reg;
                    wr_data.key             = cur_reg.key;
                    wr_data.frame           = cur_reg.new_frame;
                    wr_data.users           = 16'd1;
                    used_next[free_idx_reg] = 1'b1;
                    result.status           = sptk_pkg::STATUS_OK;
                    result.slot             = 4'(free_idx_reg);
                    result.mapped_address   = top_address - free_off_reg;
                    result.entry_frame      = cur_reg.new_frame;
                    result.users_now        = 16'd1;
                end
            end
            sptk_pkg::OP_RELEASE:
            begin
                if (!hit_found_reg)
                begin
                    result.status = sptk_pkg::STATUS_MISS;
                end
                else
                begin
                    result.status      = sptk_pkg::STATUS_OK;
                    result.slot        = 4'(hit_idx_reg);
                    result.entry_frame = hit_frame_reg;
                    if (hit_users_reg <= 16'd1)
                    begin
                        // The entry is freed; its stale contents are masked by the used bit.
                        used_next[hit_idx_reg] = 1'b0;
                        result.frame_released  = 1'b1;
                    end
                    else
                    begin
                        wr_en            = 1'b1;
                        wr_data.key      = cur_reg.key;
                        wr_data.frame    = hit_frame_reg;
                        wr_data.users    = hit_users_reg - 16'd1;
                        result.users_now = hit_users_reg - 16'd1;
                    end
                end
            end
            default:
            begin
                result.status = sptk_pkg::STATUS_KEY_ZERO;
            end
        endcase
        if (state_reg != sptk_pkg::BK_UPDATE || !out_free)
        begin
            wr_en     = 1'b0;
            used_next = used_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        rd_ptr_next     = rd_ptr_reg;
        iss_off_next    = iss_off_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        cmp_off_next    = cmp_off_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_off_next    = hit_off_reg;
        hit_frame_next  = hit_frame_reg;
        hit_users_next  = hit_users_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        free_off_next   = free_off_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;

        case (state_reg)
            sptk_pkg::BK_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop             = 1'b1;
                    cur_next        = head_item;
                    rd_ptr_next     = '0;
                    iss_off_next    = PAGE_STEP;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    if (head_item.op == sptk_pkg::OP_ZERO)
                    begin
                        state_next = sptk_pkg::BK_UPDATE;
                    end
                    else
                    begin
                        state_next = sptk_pkg::BK_SCAN;
                    end
                end
            end
            sptk_pkg::BK_SCAN:
            begin
                rd_en = (rd_ptr_reg < CNT_W'(TABLE_ENTRIES));
                if (rd_en)
                begin
                    rd_ptr_next    = rd_ptr_reg + CNT_W'(1);
                    iss_off_next   = iss_off_reg + PAGE_STEP;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_ptr_reg[IDX_W-1:0];
                    cmp_off_next   = iss_off_reg;
                end
                if (cmp_valid_reg)
                begin
                    if (rused_reg && rdata_reg.key == cur_reg.key && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = cmp_idx_reg;
                        hit_off_next   = cmp_off_reg;
                        hit_frame_next = rdata_reg.frame;
                        hit_users_next = rdata_reg.users;
                    end
                    if (!rused_reg && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                        free_off_next   = cmp_off_reg;
                    end
                end
                if (!rd_en && !cmp_valid_reg)
                begin
                    state_next = sptk_pkg::BK_UPDATE;
                end
            end
            sptk_pkg::BK_UPDATE:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = result;
                    state_next     = sptk_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sptk_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sptk_pkg::BK_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        rd_ptr_reg     <= rd_ptr_next;
        iss_off_reg    <= iss_off_next;
        cmp_idx_reg    <= cmp_idx_next;
        cmp_off_reg    <= cmp_off_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_off_reg    <= hit_off_next;
        hit_frame_reg  <= hit_frame_next;
        hit_users_reg  <= hit_users_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        free_off_reg   <= free_off_next;
        rsp_reg        <= rsp_next;
    end

    // Table memory: one read port with registered data, one write port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= table_mem[rd_ptr_reg[IDX_W-1:0]];
            rused_reg <= used_reg[rd_ptr_reg[IDX_W-1:0]];
        end
        if (wr_en)
        begin
            table_mem[wr_idx] <= wr_data;
        end
    end

endmodule
